FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: src/lpht_pkg.sv
// Shared types, codes and constants of the linear probing hash table.
package lpht_pkg;

	localparam int KEY_W   = 31;
	localparam int CFG_W   = 7;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 6;
	localparam int COLL_W  = 7;
	localparam int BIT_W   = $clog2(KEY_W);

	localparam int DEF_TABLE_DEPTH = 64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0] TABLE_SIZE_RST  = CFG_W'(64);
	localparam logic [CFG_W-1:0] MAX_INSERTS_RST = CFG_W'(64);

	localparam logic REG_TABLE_SIZE  = 1'b0;
	localparam logic REG_MAX_INSERTS = 1'b1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_SEARCH,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [COLL_W-1:0] collisions;
		logic [KEY_W-1:0]  found_key;
	} result_t;

	// One classified request: hash holds the home slot, size the slot count in use.
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [CFG_W-1:0] hash;
		logic [CFG_W-1:0] size;
	} job_t;

endpackage

FILE: src/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/lpht_front.sv
// Front end: accepts commands, applies the insert limit and hashes the key.
module lpht_front
	import lpht_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  item_t            item,
	input  logic [CFG_W-1:0] table_size,
	input  logic [CFG_W-1:0] max_inserts,
	input  logic             q_full,
	output logic             push,
	output job_t             job,
	output logic             busy
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	fstate_t          state_q;
	job_t             job_q;
	logic [BIT_W-1:0] bit_q;
	logic [CFG_W-1:0] inserts_done_q;

	logic [CFG_W-1:0] s_eff;
	logic [CFG_W:0]   rem_ext;
	logic [CFG_W-1:0] rem_next;

	always_comb begin
		if (table_size == '0) begin
			s_eff = CFG_W'(1);
		end else if (int'(table_size) > TABLE_DEPTH) begin
			s_eff = CFG_W'(TABLE_DEPTH);
		end else begin
			s_eff = table_size;
		end
	end

	// One restoring step of key mod size per cycle, most significant bit first.
	always_comb begin
		rem_ext = {job_q.hash, job_q.key[bit_q]};
		if (rem_ext >= {1'b0, job_q.size}) begin
			rem_next = CFG_W'(rem_ext - {1'b0, job_q.size});
		end else begin
			rem_next = rem_ext[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			inserts_done_q <= '0;
			bit_q          <= '0;
			job_q          <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						job_q.key  <= item.key;
						job_q.size <= s_eff;
						job_q.hash <= '0;
						bit_q      <= BIT_W'(KEY_W - 1);
						if (item.kind == KIND_INSERT) begin
							if (inserts_done_q >= max_inserts) begin
								job_q.op <= OP_IGNORE;
								state_q  <= F_PUSH;
							end else begin
								job_q.op <= OP_INSERT;
								state_q  <= F_DIV;
								if (inserts_done_q != '1) begin
									inserts_done_q <= inserts_done_q + 1'b1;
								end
							end
						end else begin
							job_q.op <= OP_SEARCH;
							state_q  <= F_DIV;
						end
					end
				end
				F_DIV: begin
					job_q.hash <= rem_next;
					bit_q      <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign push = (state_q == F_PUSH) && !q_full;
	assign job  = job_q;
	assign busy = (state_q != F_IDLE);

endmodule

FILE: src/lpht_queue.sv
// Short FIFO of classified requests between the front and back ends.
module lpht_queue
	import lpht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

endmodule

FILE: src/lpht_back.sv
// Back end: clears the slot store after reset and walks the probe sequence.
module lpht_back
	import lpht_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  job_t    head,
	output logic    pop,
	output logic    clearing,
	output logic    done,
	output result_t result
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CLR_N = (TABLE_DEPTH < 2**CFG_W) ? TABLE_DEPTH : 2**CFG_W;
	localparam int CLW   = $clog2(CLR_N);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_CHECK
	} bstate_t;

	bstate_t          state_q;
	job_t             job_q;
	logic [CFG_W-1:0] cnt_q;
	logic [CLW-1:0]   clr_q;
	logic             done_q;
	result_t          result_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic             ram_re;
	logic [KEY_W-1:0] ram_rdata;

	logic [CFG_W-1:0] cnt_inc;
	logic [CFG_W:0]   probe_sum;
	logic [CFG_W-1:0] probe_inc;
	logic             slot_empty;

	assign slot_empty = (ram_rdata == '0);
	assign cnt_inc    = cnt_q + 1'b1;
	assign probe_sum  = {1'b0, job_q.hash} + 1'b1;
	assign probe_inc  = (probe_sum == {1'b0, job_q.size}) ? '0 : probe_sum[CFG_W-1:0];

	assign ram_we    = (state_q == B_CLEAR) ||
	                   ((state_q == B_CHECK) && (job_q.op == OP_INSERT) && slot_empty);
	assign ram_waddr = (state_q == B_CLEAR) ? AW'(clr_q) : AW'(job_q.hash);
	assign ram_wdata = (state_q == B_CLEAR) ? '0 : job_q.key;
	assign ram_re    = (state_q == B_READ);

	lpht_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(job_q.hash)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			job_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLW'(CLR_N - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						job_q <= head;
						cnt_q <= '0;
						if (head.op == OP_IGNORE) begin
							done_q   <= 1'b1;
							result_q <= '{ST_IGNORED, '0, '0, '0};
						end else begin
							state_q <= B_READ;
						end
					end
				end
				B_READ: begin
					state_q <= B_CHECK;
				end
				B_CHECK: begin
					if (slot_empty) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
						if (job_q.op == OP_INSERT) begin
							result_q <= '{ST_INSERTED, job_q.hash[SLOT_W-1:0], cnt_q, '0};
						end else begin
							result_q <= '{ST_NOT_FOUND, '0, '0, '0};
						end
					end else if ((job_q.op == OP_SEARCH) && (ram_rdata == job_q.key)) begin
						done_q   <= 1'b1;
						state_q  <= B_IDLE;
						result_q <= '{ST_FOUND, job_q.hash[SLOT_W-1:0], '0, ram_rdata};
					end else if (cnt_inc == job_q.size) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
						if (job_q.op == OP_INSERT) begin
							result_q <= '{ST_FULL, '0, cnt_inc, '0};
						end else begin
							result_q <= '{ST_NOT_FOUND, '0, '0, '0};
						end
					end else begin
						cnt_q      <= cnt_inc;
						job_q.hash <= probe_inc;
						state_q    <= B_READ;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign clearing = (state_q == B_CLEAR);
	assign done     = done_q;
	assign result   = result_q;

endmodule

FILE: src/linear_probing_hash_table.sv
// Top level of the linear probing hash table.
//
//   port group  direction  handshake              beat
//   item        in         start high, busy low   kind, key
//   result      out        done strobe, one cycle status, slot, collisions, found_key
//   cfg         in         cfg_valid and cfg_ready cfg_index, cfg_data
//
// The front end accepts a command, runs the bit-serial key mod size divider and
// enters the job into the queue, waiting while it is full; ignored inserts skip the
// divider. The back end does one store read and one compare per probe. The queue
// lets the front end take a new command while the back end still probes. After
// reset busy stays high while the slot store is cleared. Results cannot be held off.
module linear_probing_hash_table
	import lpht_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] table_size_q;
	logic [CFG_W-1:0] max_inserts_q;

	logic front_busy;
	logic clearing;
	logic accept;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t head;

	assign cfg_ready = 1'b1;
	assign busy      = front_busy || clearing;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q  <= TABLE_SIZE_RST;
			max_inserts_q <= MAX_INSERTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TABLE_SIZE:  table_size_q  <= cfg_data;
				REG_MAX_INSERTS: max_inserts_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lpht_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.table_size  (table_size_q),
		.max_inserts (max_inserts_q),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job),
		.busy        (front_busy)
	);

	lpht_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	lpht_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

FILE: src/lpht_checker.sv
// Port-level checks of the hash table, bound to the top level.
`include "assert_macros.svh"

module lpht_port_checks
	import lpht_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	`ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMP(a_ignored_zero, clk, arst_n, done && (result.status == ST_IGNORED), result.slot == '0 && result.collisions == '0 && result.found_key == '0)
	`ASSERT_IMP(a_key_only_found, clk, arst_n, done && (result.status != ST_FOUND), result.found_key == '0)
	`ASSERT_IMP(a_search_no_coll, clk, arst_n, done && (result.status == ST_NOT_FOUND || result.status == ST_FOUND), result.collisions == '0)

endmodule

bind linear_probing_hash_table lpht_port_checks u_lpht_port_checks (.*);
